FILE: hw/rtl/cbs_pkg.sv
`default_nettype none

package cbs_pkg;

  localparam int unsigned CMDQ_DEPTH = 2;

  localparam logic [15:0] ADDR_MASK  = 16'hE001;
  localparam logic [15:0] ADDR_OUTER = 16'h6000;
  localparam logic [15:0] ADDR_CTRL  = 16'h8000;
  localparam logic [15:0] ADDR_BANK  = 16'h8001;
  localparam logic [15:0] ADDR_ARM   = 16'hA001;

  localparam logic [8:0] PRG_COUNT_RST = 9'd64;
  localparam logic [7:0] PRG_RST_SLOT2 = 8'(PRG_COUNT_RST - 9'd2);
  localparam logic [7:0] PRG_RST_SLOT3 = 8'(PRG_COUNT_RST - 9'd1);

  localparam logic [5:0] PRG_MASK_BITS = 6'h3F;
  localparam logic [3:0] CHR_LOW_BITS  = 4'hF;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_OUTER,
    OP_CTRL,
    OP_BANK,
    OP_ARM
  } cbs_op_t;

  typedef struct packed {
    cbs_op_t    op;
    logic [7:0] data;
  } cbs_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cbs_front.sv
`default_nettype none

module cbs_front
  import cbs_pkg::*;
(
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic        q_full,
  output logic             push,
  output cbs_cmd_t         cmd
);

  logic [15:0] addr_dec;

  assign addr_dec = in_address & ADDR_MASK;
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    cmd.data = in_write_data;
    unique case (addr_dec)
      ADDR_OUTER: cmd.op = OP_OUTER;
      ADDR_CTRL:  cmd.op = OP_CTRL;
      ADDR_BANK:  cmd.op = OP_BANK;
      ADDR_ARM:   cmd.op = OP_ARM;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cbs_cmdq.sv
`default_nettype none

module cbs_cmdq
  import cbs_pkg::*;
#(
  parameter int unsigned DEPTH = CMDQ_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire cbs_cmd_t push_cmd,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output cbs_cmd_t      head_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cbs_cmd_t         entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cbs_back.sv
`default_nettype none

module cbs_back
  import cbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        q_valid,
  input  wire cbs_cmd_t    q_cmd,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       prg_map [4],
  output logic [12:0]      chr_map [8]
);

  logic [8:0]  count_r;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  bank_r [8];
  logic [7:0]  bank_nxt [8];
  logic [7:0]  outer_r [4];
  logic [7:0]  outer_nxt [4];
  logic        armed_r, armed_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [7:0]  prg_r [4];
  logic [7:0]  prg_nxt [4];
  logic [12:0] chr_r [8];
  logic [12:0] chr_nxt [8];
  logic        recomp;
  logic        valid_r;
  logic [11:0] c [6];
  logic [12:0] c0_inc, c1_inc;
  logic [7:0]  m, p0, p1, p2, p3;
  logic [8:0]  count_m1;

  assign pop       = q_valid && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign prg_map   = prg_r;
  assign chr_map   = chr_r;
  assign count_m1  = count_r - 9'd1;

  always_comb begin
    ctrl_nxt  = ctrl_r;
    bank_nxt  = bank_r;
    outer_nxt = outer_r;
    armed_nxt = armed_r;
    idx_nxt   = idx_r;
    recomp    = 1'b0;
    unique case (q_cmd.op)
      OP_OUTER: begin
        if (armed_r) begin
          outer_nxt[idx_r] = q_cmd.data;
          idx_nxt          = idx_r + 2'd1;
          recomp           = (idx_r == 2'd3);
        end
      end
      OP_CTRL: begin
        ctrl_nxt = q_cmd.data;
        recomp   = 1'b1;
      end
      OP_BANK: begin
        bank_nxt[ctrl_r[2:0]] = q_cmd.data;
        recomp                = 1'b1;
      end
      OP_ARM: begin
        if (q_cmd.data[7]) begin
          armed_nxt = 1'b1;
          idx_nxt   = 2'd0;
        end else begin
          armed_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      c[i] = ({4'd0, bank_nxt[i]} | {outer_nxt[1], 4'd0})
           & {outer_nxt[2], CHR_LOW_BITS};
    end
    c0_inc = {1'b0, c[0]} + 13'd1;
    c1_inc = {1'b0, c[1]} + 13'd1;
    m  = {2'b00, outer_nxt[3][5:0] ^ PRG_MASK_BITS};
    p0 = (bank_nxt[6] & m) | outer_nxt[1];
    p1 = (bank_nxt[7] & m) | outer_nxt[1];
    p3 = m | outer_nxt[1];
    p2 = p3 & count_m1[7:0];

    prg_nxt = prg_r;
    chr_nxt = chr_r;
    if (recomp) begin
      if (ctrl_nxt[7]) begin
        chr_nxt[0] = {1'b0, c[2]};
        chr_nxt[1] = {1'b0, c[3]};
        chr_nxt[2] = {1'b0, c[4]};
        chr_nxt[3] = {1'b0, c[5]};
        chr_nxt[4] = {1'b0, c[0]};
        chr_nxt[5] = c0_inc;
        chr_nxt[6] = {1'b0, c[1]};
        chr_nxt[7] = c1_inc;
      end else begin
        chr_nxt[0] = {1'b0, c[0]};
        chr_nxt[1] = c0_inc;
        chr_nxt[2] = {1'b0, c[1]};
        chr_nxt[3] = c1_inc;
        chr_nxt[4] = {1'b0, c[2]};
        chr_nxt[5] = {1'b0, c[3]};
        chr_nxt[6] = {1'b0, c[4]};
        chr_nxt[7] = {1'b0, c[5]};
      end
      if (ctrl_nxt[6]) begin
        prg_nxt[0] = p2;
        prg_nxt[2] = p0;
      end else begin
        prg_nxt[0] = p0;
        prg_nxt[2] = p2;
      end
      prg_nxt[1] = p1;
      prg_nxt[3] = p3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= PRG_COUNT_RST;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ctrl_r  <= '0;
      armed_r <= 1'b0;
      idx_r   <= '0;
      for (int i = 0; i < 8; i++) begin
        bank_r[i] <= '0;
        chr_r[i]  <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        outer_r[i] <= '0;
      end
      prg_r[0] <= 8'd0;
      prg_r[1] <= 8'd1;
      prg_r[2] <= PRG_RST_SLOT2;
      prg_r[3] <= PRG_RST_SLOT3;
    end else begin
      if (pop) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
      if (pop) begin
        ctrl_r  <= ctrl_nxt;
        bank_r  <= bank_nxt;
        outer_r <= outer_nxt;
        armed_r <= armed_nxt;
        idx_r   <= idx_nxt;
        prg_r   <= prg_nxt;
        chr_r   <= chr_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cartridge_bank_switch_outer_regs.sv
// Bank switcher for a cartridge with outer registers. Each input item is one
// CPU write (in_address, in_write_data); the address is decoded with the mask
// 0xE001 and the write updates the control, bank, outer or arm registers.
// Every accepted item returns exactly one result item on the out_ channel:
// the four 8K program banks and the eight 1K character banks now in effect.
// A front decoder classifies each write into a two-entry command queue, and
// a back stage applies it, recomputes the mapping and holds the result in
// the output register. An accepted item passes through the queue entry and then
// the output register; the block sustains one item per clock while out_stall is low,
// with the update and recompute done combinationally in the back stage.
// The cfg_ port writes the program bank count, which takes effect at the
// next recompute. Synchronous reset clears all registers, empties the queue,
// sets the bank count to 64 and maps banks 0, 1, 62 and 63.
// When the receiver stalls, the output item holds, the queue fills, and
// in_stall rises once both queue entries are occupied.
`default_nettype none

module cartridge_bank_switch_outer_regs
  import cbs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = CMDQ_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_prg_slot0,
  output logic [7:0]       out_prg_slot1,
  output logic [7:0]       out_prg_slot2,
  output logic [7:0]       out_prg_slot3,
  output logic [12:0]      out_chr_slot0,
  output logic [12:0]      out_chr_slot1,
  output logic [12:0]      out_chr_slot2,
  output logic [12:0]      out_chr_slot3,
  output logic [12:0]      out_chr_slot4,
  output logic [12:0]      out_chr_slot5,
  output logic [12:0]      out_chr_slot6,
  output logic [12:0]      out_chr_slot7
);

  cbs_cmd_t    push_cmd;
  cbs_cmd_t    head_cmd;
  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        pop;
  logic [7:0]  prg_map [4];
  logic [12:0] chr_map [8];

  cbs_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .q_full        (q_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  cbs_cmdq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  cbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .prg_map   (prg_map),
    .chr_map   (chr_map)
  );

  assign out_prg_slot0 = prg_map[0];
  assign out_prg_slot1 = prg_map[1];
  assign out_prg_slot2 = prg_map[2];
  assign out_prg_slot3 = prg_map[3];
  assign out_chr_slot0 = chr_map[0];
  assign out_chr_slot1 = chr_map[1];
  assign out_chr_slot2 = chr_map[2];
  assign out_chr_slot3 = chr_map[3];
  assign out_chr_slot4 = chr_map[4];
  assign out_chr_slot5 = chr_map[5];
  assign out_chr_slot6 = chr_map[6];
  assign out_chr_slot7 = chr_map[7];

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top
  import cbs_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_LEN = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int CTRL_CHR_SWAP = 7;
  localparam int CTRL_PRG_SWAP = 6;
  localparam int ARM_BIT = 7;
  localparam logic [7:0] ARM_FLAG = 8'h80;

  typedef struct packed {
    logic [3:0][7:0]  prg;
    logic [7:0][12:0] chr;
  } bank_map_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [8:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_address;
  logic [7:0]  in_write_data;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_prg_slot0, out_prg_slot1, out_prg_slot2, out_prg_slot3;
  logic [12:0] out_chr_slot0, out_chr_slot1, out_chr_slot2, out_chr_slot3;
  logic [12:0] out_chr_slot4, out_chr_slot5, out_chr_slot6, out_chr_slot7;

  logic [7:0]  bank_sh [8];
  logic [7:0]  outer_sh [4];
  logic [7:0]  ctrl_sh;
  logic        outer_armed_sh;
  logic [1:0]  outer_idx_sh;
  logic [8:0]  bank_count_sh;
  bank_map_t   map_sh;
  bank_map_t   expected_maps [$];

  int          sender_idle_pct;
  int          receiver_idle_pct;
  int          writes_sent;
  int          errors;
  logic        hold_off;
  int          hold_cycles;

  cartridge_bank_switch_outer_regs i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_prg_slot0 (out_prg_slot0),
    .out_prg_slot1 (out_prg_slot1),
    .out_prg_slot2 (out_prg_slot2),
    .out_prg_slot3 (out_prg_slot3),
    .out_chr_slot0 (out_chr_slot0),
    .out_chr_slot1 (out_chr_slot1),
    .out_chr_slot2 (out_chr_slot2),
    .out_chr_slot3 (out_chr_slot3),
    .out_chr_slot4 (out_chr_slot4),
    .out_chr_slot5 (out_chr_slot5),
    .out_chr_slot6 (out_chr_slot6),
    .out_chr_slot7 (out_chr_slot7)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void remap_banks();
    logic [12:0] c [6];
    logic [7:0]  m, p0, p1, p2, p3;
    for (int i = 0; i < 6; i++) begin
      c[i] = ({5'd0, bank_sh[i]} | {1'b0, outer_sh[1], 4'd0})
           & {1'b0, outer_sh[2], CHR_LOW_BITS};
    end
    if (ctrl_sh[CTRL_CHR_SWAP]) begin
      map_sh.chr = {c[1] + 13'd1, c[1], c[0] + 13'd1, c[0], c[5], c[4], c[3], c[2]};
    end else begin
      map_sh.chr = {c[5], c[4], c[3], c[2], c[1] + 13'd1, c[1], c[0] + 13'd1, c[0]};
    end
    m  = {2'b00, outer_sh[3][5:0] ^ PRG_MASK_BITS};
    p0 = (bank_sh[6] & m) | outer_sh[1];
    p1 = (bank_sh[7] & m) | outer_sh[1];
    p3 = m | outer_sh[1];
    p2 = p3 & 8'(bank_count_sh - 9'd1);
    if (ctrl_sh[CTRL_PRG_SWAP]) begin
      map_sh.prg = {p3, p0, p1, p2};
    end else begin
      map_sh.prg = {p3, p2, p1, p0};
    end
  endfunction

  function automatic void apply_cpu_write(input logic [15:0] addr, input logic [7:0] data);
    case (addr & ADDR_MASK)
      ADDR_OUTER: begin
        if (outer_armed_sh) begin
          outer_sh[outer_idx_sh] = data;
          outer_idx_sh = outer_idx_sh + 2'd1;
          if (outer_idx_sh == 2'd0) remap_banks();
        end
      end
      ADDR_CTRL: begin
        ctrl_sh = data;
        remap_banks();
      end
      ADDR_BANK: begin
        bank_sh[ctrl_sh[2:0]] = data;
        remap_banks();
      end
      ADDR_ARM: begin
        if (data[ARM_BIT]) begin
          outer_armed_sh = 1'b1;
          outer_idx_sh = 2'd0;
        end else begin
          outer_armed_sh = 1'b0;
        end
      end
      default: ;
    endcase
    expected_maps.push_back(map_sh);
  endfunction

  task automatic send_write(input logic [15:0] addr, input logic [7:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_address    <= addr;
    in_write_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_cpu_write(addr, data);
    writes_sent++;
  endtask

  task automatic send_decoded(input logic [15:0] target, input logic [7:0] data);
    send_write((16'($urandom) & ~ADDR_MASK) | target, data);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_maps.size() != 0) @(posedge clk);
  endtask

  task automatic write_bank_count(input logic [8:0] count);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    bank_count_sh = count;
  endtask

  task automatic random_burst();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 35) begin
      send_decoded(ADDR_ARM, 8'($urandom) | ARM_FLAG);
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 4;
      repeat (n) send_decoded(ADDR_OUTER, 8'($urandom));
    end else if (kind < 65) begin
      send_decoded(ADDR_CTRL, 8'($urandom));
      repeat ($urandom_range(1, 2)) send_decoded(ADDR_BANK, 8'($urandom));
    end else if (kind < 75) begin
      send_decoded(ADDR_CTRL, 8'($urandom));
    end else if (kind < 85) begin
      send_decoded(ADDR_ARM, 8'($urandom) & ~ARM_FLAG);
      send_decoded(ADDR_OUTER, 8'($urandom));
    end else begin
      send_write(16'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_bursts(input int n_items);
    writes_sent = 0;
    while (writes_sent < n_items) random_burst();
  endtask

  task automatic test_reset_mapping();
    send_write(16'h0000, 8'h00);
    send_write(16'hFFFF, 8'hFF);
    send_write(ADDR_OUTER, 8'hFF);
  endtask

  task automatic test_decode_directed();
    send_write(ADDR_CTRL, 8'h00);
    send_write(ADDR_BANK, 8'hFF);
    send_write(16'h9FFE, 8'h01);
    send_write(16'h9FFF, 8'h80);
    send_write(ADDR_CTRL, 8'h87);
    send_write(ADDR_BANK, 8'hFF);
    send_write(ADDR_CTRL, 8'h46);
    send_write(16'h9FFF, 8'hAA);
    send_write(ADDR_ARM, 8'h80);
    send_write(ADDR_OUTER, 8'hFF);
    send_write(ADDR_OUTER, 8'hFF);
    send_write(ADDR_OUTER, 8'hFF);
    send_write(ADDR_OUTER, 8'h00);
    send_write(ADDR_ARM, 8'hFF);
    send_write(ADDR_OUTER, 8'h12);
    send_write(16'hBFFF, 8'hFF);
    send_write(16'h7FFE, 8'h00);
    send_write(16'h7FFE, 8'h0F);
    send_write(16'h7FFE, 8'hF0);
    send_write(16'h7FFE, 8'h3F);
    send_write(ADDR_ARM, 8'h7F);
    send_write(ADDR_OUTER, 8'h55);
    send_write(ADDR_CTRL, 8'hC0);
    send_write(16'hA000, 8'hFF);
  endtask

  task automatic test_random_traffic(input logic [8:0] count, input int snd_pct,
                                     input int rcv_pct, input int n_items);
    write_bank_count(count);
    sender_idle_pct   = snd_pct;
    receiver_idle_pct = rcv_pct;
    run_bursts(n_items);
  endtask

  task automatic test_odd_bank_counts();
    write_bank_count(9'd0);
    run_bursts(40);
    write_bank_count(9'd511);
    run_bursts(40);
  endtask

  task automatic test_output_backpressure();
    wait_for_results();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_off <= 1'b1;
    run_bursts(60);
  endtask

  always @(posedge clk) begin : check_results
    bank_map_t got;
    bank_map_t want;
    if (hold_off) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles == HOLD_LEN - 1) hold_off <= 1'b0;
    end else begin
      hold_cycles <= 0;
      out_stall   <= ($urandom_range(99) < receiver_idle_pct);
    end
    if (rst_n && out_valid && !out_stall) begin
      got.prg = {out_prg_slot3, out_prg_slot2, out_prg_slot1, out_prg_slot0};
      got.chr = {out_chr_slot7, out_chr_slot6, out_chr_slot5, out_chr_slot4,
                 out_chr_slot3, out_chr_slot2, out_chr_slot1, out_chr_slot0};
      if (expected_maps.size() == 0) begin
        $error("result item with no write pending");
        errors++;
      end else begin
        want = expected_maps.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got.prg[i] !== want.prg[i]) begin
            $error("prg_slot%0d: expected %0d, got %0d", i, want.prg[i], got.prg[i]);
            errors++;
          end
        end
        for (int i = 0; i < 8; i++) begin
          if (got.chr[i] !== want.chr[i]) begin
            $error("chr_slot%0d: expected %0d, got %0d", i, want.chr[i], got.chr[i]);
            errors++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_address    <= '0;
    in_write_data <= '0;
    out_stall     <= 1'b0;
    hold_off      <= 1'b0;
    hold_cycles   <= 0;
    errors            = 0;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    foreach (bank_sh[i]) bank_sh[i] = '0;
    foreach (outer_sh[i]) outer_sh[i] = '0;
    ctrl_sh        = '0;
    outer_armed_sh = 1'b0;
    outer_idx_sh   = '0;
    bank_count_sh  = PRG_COUNT_RST;
    map_sh.chr     = '0;
    map_sh.prg     = {PRG_RST_SLOT3, PRG_RST_SLOT2, 8'd1, 8'd0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_mapping();
    test_decode_directed();
    test_random_traffic(9'd2, 25, 64, 420);
    test_random_traffic(9'd256, 64, 25, 420);
    test_random_traffic(9'(1 << $urandom_range(1, 8)), 0, 0, 420);
    test_odd_bank_counts();
    test_output_backpressure();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
